FILE: design/rbs_pkg.sv
package rbs_pkg;

  // Number format and derived widths.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LEN_WIDTH   = COORD_WIDTH - 1;
  localparam int NUM_AXES    = 3;
  localparam int NUM_DIVS    = 2 * NUM_AXES;

  // Doubled local coordinate, slab face numerators and their magnitudes.
  localparam int LOC_WIDTH   = COORD_WIDTH + 2;
  localparam int NUM_WIDTH   = COORD_WIDTH + 4;
  localparam int MAG_WIDTH   = NUM_WIDTH - 1;

  // Divider: denominator is twice the direction magnitude.
  localparam int DEN_WIDTH   = COORD_WIDTH + 1;
  localparam int QUO_BITS    = COORD_WIDTH - 1;
  localparam int DIVD_WIDTH  = MAG_WIDTH + FRAC_BITS;
  localparam int HEAD_WIDTH  = DIVD_WIDTH - QUO_BITS;
  localparam int DIV_LAT     = QUO_BITS + 1;

  // Entry point arithmetic.
  localparam int PROD_WIDTH  = COORD_WIDTH + LEN_WIDTH;
  localparam int STEP_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int SUM_WIDTH   = STEP_WIDTH + 2;

  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LEN_WIDTH-1:0]          len_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_EXTENT_X = 3'd3,
    REG_EXTENT_Y = 3'd4,
    REG_EXTENT_Z = 3'd5
  } cfg_reg_t;

  // Per-ray data that rides alongside the arithmetic.
  typedef struct packed {
    coord_t [NUM_AXES-1:0] org;
    coord_t [NUM_AXES-1:0] dir;
    len_t                  len;
    logic [NUM_AXES-1:0]   dz;
    logic                  par_fail;
  } side_t;

endpackage

FILE: design/rbs_prep.sv
module rbs_prep (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  logic                                            in_valid,
  input  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0]         org,
  input  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0]         dir,
  input  rbs_pkg::len_t                                   len,
  input  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0]         center,
  input  rbs_pkg::len_t [rbs_pkg::NUM_AXES-1:0]           extent,
  output logic                                            out_valid,
  output rbs_pkg::side_t                                  side,
  output logic [rbs_pkg::NUM_DIVS-1:0][rbs_pkg::MAG_WIDTH-1:0] mag,
  output logic [rbs_pkg::NUM_DIVS-1:0]                    neg,
  output logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DEN_WIDTH-1:0] den
);
  import rbs_pkg::*;

  logic  v1_r, v2_r, v3_r;
  side_t s1_r, s2_r, s3_r;
  side_t s1_nxt, s2_nxt;
  logic signed [LOC_WIDTH-1:0] loc_r [NUM_AXES];
  logic signed [LOC_WIDTH-1:0] loc_nxt [NUM_AXES];
  logic signed [NUM_WIDTH-1:0] num_r [NUM_DIVS];
  logic signed [NUM_WIDTH-1:0] num_nxt [NUM_DIVS];
  logic [NUM_DIVS-1:0][MAG_WIDTH-1:0] mag_r, mag_nxt;
  logic [NUM_DIVS-1:0] neg_r, neg_nxt;
  logic [NUM_AXES-1:0][DEN_WIDTH-1:0] den_r, den_nxt;

  // Stage 1: doubled origin relative to the box center.
  always_comb begin
    logic [COORD_WIDTH:0] diff;
    s1_nxt = '0;
    s1_nxt.org = org;
    s1_nxt.dir = dir;
    s1_nxt.len = len;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff = {org[a][COORD_WIDTH-1], org[a]} - {center[a][COORD_WIDTH-1], center[a]};
      loc_nxt[a] = $signed({diff, 1'b0});
      s1_nxt.dz[a] = (dir[a] == '0);
    end
  end

  // Stage 2: face numerators and the containment test of parallel axes.
  always_comb begin
    logic signed [NUM_WIDTH-1:0] loc_e;
    logic signed [NUM_WIDTH-1:0] ext_e;
    s2_nxt = s1_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      loc_e = NUM_WIDTH'(loc_r[a]);
      ext_e = $signed({{(NUM_WIDTH-LEN_WIDTH){1'b0}}, extent[a]});
      num_nxt[2*a]   = -ext_e - loc_e;
      num_nxt[2*a+1] = ext_e - loc_e;
      if (s1_r.dz[a] && ((loc_e < -ext_e) || (loc_e > ext_e))) begin
        s2_nxt.par_fail = 1'b1;
      end
    end
  end

  // Stage 3: magnitudes, quotient signs and denominators for the dividers.
  always_comb begin
    logic [COORD_WIDTH-1:0] absd;
    for (int j = 0; j < NUM_DIVS; j++) begin
      mag_nxt[j] = MAG_WIDTH'(num_r[j][NUM_WIDTH-1] ? -num_r[j] : num_r[j]);
      neg_nxt[j] = num_r[j][NUM_WIDTH-1] ^ s2_r.dir[j/2][COORD_WIDTH-1];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      absd = s2_r.dir[a][COORD_WIDTH-1] ? -s2_r.dir[a] : s2_r.dir[a];
      den_nxt[a] = {absd, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s2_r;
      loc_r <= loc_nxt;
      num_r <= num_nxt;
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      den_r <= den_nxt;
    end
  end

  assign out_valid = v3_r;
  assign side      = s3_r;
  assign mag       = mag_r;
  assign neg       = neg_r;
  assign den       = den_r;

endmodule

FILE: design/rbs_div.sv
module rbs_div (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [rbs_pkg::MAG_WIDTH-1:0]  mag,
  input  logic [rbs_pkg::DEN_WIDTH-1:0]  den,
  input  logic                           neg,
  output logic [rbs_pkg::QUO_BITS-1:0]   quo,
  output logic                           ovf,
  output logic                           neg_o
);
  import rbs_pkg::*;

  // One restoring quotient bit per stage, most significant first.
  logic [DEN_WIDTH-1:0]  rem_r [QUO_BITS+1];
  logic [DEN_WIDTH-1:0]  den_r [QUO_BITS+1];
  logic [QUO_BITS-1:0]   low_r [QUO_BITS+1];
  logic [QUO_BITS-1:0]   quo_r [QUO_BITS+1];
  logic                  ovf_r [QUO_BITS+1];
  logic                  neg_r [QUO_BITS+1];
  logic [DIVD_WIDTH-1:0] dvd;
  logic [HEAD_WIDTH-1:0] head;

  // Entry stage: a quotient that needs more bits than the result is flagged as an overflow.
  assign dvd  = {mag, {FRAC_BITS{1'b0}}};
  assign head = dvd[DIVD_WIDTH-1:QUO_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= DEN_WIDTH'(head);
      den_r[0] <= den;
      low_r[0] <= dvd[QUO_BITS-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= (DIVD_WIDTH'(head) >= DIVD_WIDTH'(den));
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int B = QUO_BITS - 1 - k;
    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH:0]   diff;
    logic                 ge;
    logic [QUO_BITS-1:0]  quo_nxt;

    always_comb begin
      trial   = {rem_r[k], low_r[k][B]};
      diff    = trial - {1'b0, den_r[k]};
      ge      = (trial >= {1'b0, den_r[k]});
      quo_nxt = quo_r[k];
      quo_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
        den_r[k+1] <= den_r[k];
        low_r[k+1] <= low_r[k];
        quo_r[k+1] <= quo_nxt;
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign quo   = quo_r[QUO_BITS];
  assign ovf   = ovf_r[QUO_BITS];
  assign neg_o = neg_r[QUO_BITS];

endmodule

FILE: design/rbs_post.sv
module rbs_post (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  rbs_pkg::side_t                                side,
  input  logic [rbs_pkg::NUM_DIVS-1:0][rbs_pkg::QUO_BITS-1:0] quo,
  input  logic [rbs_pkg::NUM_DIVS-1:0]                  ovf,
  input  logic [rbs_pkg::NUM_DIVS-1:0]                  neg,
  output logic                                          out_valid,
  output logic                                          hit,
  output rbs_pkg::len_t                                 entry,
  output rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0]       point
);
  import rbs_pkg::*;

  localparam logic [COORD_WIDTH:0] CAP_POS = {2'b00, {QUO_BITS{1'b1}}};
  localparam logic [COORD_WIDTH:0] CAP_NEG = {2'b01, {QUO_BITS{1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
    SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = -SAT_HI - SUM_WIDTH'(1);

  logic  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  side_t s1_r, s2_r, s3_r, s4_r, s5_r;
  coord_t t_r   [NUM_DIVS];
  coord_t t_nxt [NUM_DIVS];
  coord_t lo_r [NUM_AXES];
  coord_t hi_r [NUM_AXES];
  coord_t lo_nxt [NUM_AXES];
  coord_t hi_nxt [NUM_AXES];
  coord_t tmin_r, tmax_r, tmin_nxt, tmax_nxt;
  logic   hit4_r, hit5_r, hit6_r, hit4_nxt;
  len_t   ent4_r, ent5_r, ent6_r, ent4_nxt;
  logic [PROD_WIDTH-1:0] prod_r   [NUM_AXES];
  logic [PROD_WIDTH-1:0] prod_nxt [NUM_AXES];
  coord_t pt_r   [NUM_AXES];
  coord_t pt_nxt [NUM_AXES];

  // Stage 1: saturate and sign the crossing parameters.
  always_comb begin
    logic [COORD_WIDTH:0] base;
    for (int j = 0; j < NUM_DIVS; j++) begin
      if (ovf[j]) begin
        base = neg[j] ? CAP_NEG : CAP_POS;
      end else begin
        base = {2'b00, quo[j]};
      end
      t_nxt[j] = COORD_WIDTH'(neg[j] ? -base : base);
    end
  end

  // Stage 2: order the two face crossings of each axis.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (t_r[2*a] > t_r[2*a+1]) begin
        lo_nxt[a] = t_r[2*a+1];
        hi_nxt[a] = t_r[2*a];
      end else begin
        lo_nxt[a] = t_r[2*a];
        hi_nxt[a] = t_r[2*a+1];
      end
    end
  end

  // Stage 3: narrow the window [0, length] by every non-parallel axis.
  always_comb begin
    tmin_nxt = '0;
    tmax_nxt = $signed({1'b0, s2_r.len});
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!s2_r.dz[a] && (lo_r[a] > tmin_nxt)) begin
        tmin_nxt = lo_r[a];
      end
      if (!s2_r.dz[a] && (hi_r[a] < tmax_nxt)) begin
        tmax_nxt = hi_r[a];
      end
    end
  end

  // Stage 4: hit decision; the entry parameter is zero on a miss.
  always_comb begin
    hit4_nxt = !s3_r.par_fail && (tmin_r <= tmax_r);
    ent4_nxt = hit4_nxt ? tmin_r[LEN_WIDTH-1:0] : '0;
  end

  // Stage 5: direction magnitude times the entry parameter.
  always_comb begin
    logic [COORD_WIDTH-1:0] absd;
    for (int a = 0; a < NUM_AXES; a++) begin
      absd = s4_r.dir[a][COORD_WIDTH-1] ? -s4_r.dir[a] : s4_r.dir[a];
      prod_nxt[a] = PROD_WIDTH'(absd) * PROD_WIDTH'(ent4_r);
    end
  end

  // Stage 6: entry point, saturated to the coordinate range and zero on a miss.
  always_comb begin
    logic signed [SUM_WIDTH-1:0] step;
    logic signed [SUM_WIDTH-1:0] sum;
    for (int a = 0; a < NUM_AXES; a++) begin
      step = $signed(SUM_WIDTH'(prod_r[a][PROD_WIDTH-1:FRAC_BITS]));
      if (s5_r.dir[a][COORD_WIDTH-1]) begin
        step = -step;
      end
      sum = SUM_WIDTH'($signed(s5_r.org[a])) + step;
      if (!hit5_r) begin
        pt_nxt[a] = '0;
      end else if (sum > SAT_HI) begin
        pt_nxt[a] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum < SAT_LO) begin
        pt_nxt[a] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        pt_nxt[a] = sum[COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= side;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      s4_r   <= s3_r;
      s5_r   <= s4_r;
      t_r    <= t_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
      hit4_r <= hit4_nxt;
      ent4_r <= ent4_nxt;
      hit5_r <= hit4_r;
      ent5_r <= ent4_r;
      prod_r <= prod_nxt;
      hit6_r <= hit5_r;
      ent6_r <= ent5_r;
      pt_r   <= pt_nxt;
    end
  end

  assign out_valid = v6_r;
  assign hit       = hit6_r;
  assign entry     = ent6_r;
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      point[a] = pt_r[a];
    end
  end

endmodule

FILE: design/ray_box_slab_intersect.sv
// Ray against axis-aligned box by the slab method, signed Q16.16.
// From input transfer to result a ray passes 3 setup stages, 32 stages of
// the bit-per-stage dividers and 6 window and entry point stages.
// Throughput: one ray per cycle; the whole pipeline holds while the result
// register waits under out_stall. Synchronous active-low reset empties the
// pipeline and clears the box registers to zero.
module ray_box_slab_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rbs_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [rbs_pkg::COORD_WIDTH-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbs_pkg::coord_t                     in_origin_x,
  input  rbs_pkg::coord_t                     in_origin_y,
  input  rbs_pkg::coord_t                     in_origin_z,
  input  rbs_pkg::coord_t                     in_dir_x,
  input  rbs_pkg::coord_t                     in_dir_y,
  input  rbs_pkg::coord_t                     in_dir_z,
  input  rbs_pkg::len_t                       in_ray_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output rbs_pkg::len_t                       out_entry_param,
  output rbs_pkg::coord_t                     out_point_x,
  output rbs_pkg::coord_t                     out_point_y,
  output rbs_pkg::coord_t                     out_point_z
);
  import rbs_pkg::*;

  logic adv;
  coord_t [NUM_AXES-1:0] center_r;
  len_t   [NUM_AXES-1:0] extent_r;
  coord_t [NUM_AXES-1:0] org_v, dir_v, point_v;

  logic                               prep_valid;
  side_t                              prep_side;
  logic [NUM_DIVS-1:0][MAG_WIDTH-1:0] mag;
  logic [NUM_DIVS-1:0]                neg;
  logic [NUM_AXES-1:0][DEN_WIDTH-1:0] den;
  logic [NUM_DIVS-1:0][QUO_BITS-1:0]  quo;
  logic [NUM_DIVS-1:0]                ovf;
  logic [NUM_DIVS-1:0]                quo_neg;

  logic  dly_valid_r [DIV_LAT];
  side_t dly_side_r  [DIV_LAT];

  // The pipeline moves unless a finished result is held back.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Box registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      extent_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_r[0] <= cfg_data;
        REG_CENTER_Y: center_r[1] <= cfg_data;
        REG_CENTER_Z: center_r[2] <= cfg_data;
        REG_EXTENT_X: extent_r[0] <= cfg_data[LEN_WIDTH-1:0];
        REG_EXTENT_Y: extent_r[1] <= cfg_data[LEN_WIDTH-1:0];
        REG_EXTENT_Z: extent_r[2] <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign org_v = {in_origin_z, in_origin_y, in_origin_x};
  assign dir_v = {in_dir_z, in_dir_y, in_dir_x};

  rbs_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .org       (org_v),
    .dir       (dir_v),
    .len       (in_ray_length),
    .center    (center_r),
    .extent    (extent_r),
    .out_valid (prep_valid),
    .side      (prep_side),
    .mag       (mag),
    .neg       (neg),
    .den       (den)
  );

  // Two face crossings per axis.
  for (genvar j = 0; j < NUM_DIVS; j++) begin : g_div
    rbs_div u_div (
      .clk   (clk),
      .adv   (adv),
      .mag   (mag[j]),
      .den   (den[j/2]),
      .neg   (neg[j]),
      .quo   (quo[j]),
      .ovf   (ovf[j]),
      .neg_o (quo_neg[j])
    );
  end

  // Ray data and valid bits follow the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dly_valid_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dly_valid_r[0] <= prep_valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_valid_r[i] <= dly_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_side_r[0] <= prep_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_side_r[i] <= dly_side_r[i-1];
      end
    end
  end

  rbs_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dly_valid_r[DIV_LAT-1]),
    .side      (dly_side_r[DIV_LAT-1]),
    .quo       (quo),
    .ovf       (ovf),
    .neg       (quo_neg),
    .out_valid (out_valid),
    .hit       (out_hit),
    .entry     (out_entry_param),
    .point     (point_v)
  );

  assign out_point_x = point_v[0];
  assign out_point_y = point_v[1];
  assign out_point_z = point_v[2];

endmodule
